FILE: rtl/core/sst_pkg.sv
// Shared types and constants for the sphere-tracing ray marcher.
package sst_pkg;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Fraction bits of the Q16.16 coordinates and width of the step counter
  localparam int unsigned FracBits  = 16;
  localparam int unsigned StepWidth = 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SHAPE     = 3'd0,
    REG_SIZE      = 3'd1,
    REG_PERIOD    = 3'd2,
    REG_REP_EN    = 3'd3,
    REG_MAX_STEPS = 3'd4,
    REG_HIT_THR   = 3'd5,
    REG_FAR_LIM   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SHAPE_SPHERE = 2'd0,
    SHAPE_BOX    = 2'd1,
    SHAPE_TORUS  = 2'd2
  } shape_e;

  typedef enum logic [1:0] {
    CLS_MISS = 2'd0,
    CLS_NEAR = 2'd1,
    CLS_FAR  = 2'd2
  } hit_class_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_WRAP,
    ST_MOD,
    ST_SQ,
    ST_ROOT1,
    ST_MID,
    ST_ROOT2,
    ST_DIST,
    ST_ADV,
    ST_DONE
  } sst_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture ray, clear travel and step
    logic mul;        // form direction times travel
    logic wrap;       // form offset point, start modulo
    logic mod_step;   // one restoring division step
    logic sq;         // square components, first sum
    logic root_start; // start the integer root
    logic root_step;  // one root step
    logic mid;        // torus second sum
    logic form_dist;  // form distance
    logic adv;        // add distance to travel, bump step
  } sst_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mod_done;
    logic root_done;
    logic limit_hit;  // step count reached limit
    logic is_hit;     // distance below threshold
    logic torus;      // second root pass needed
  } sst_stat_t;

endpackage

FILE: rtl/core/sst_if.sv
// Valid/ready channel interfaces for rays, results and configuration writes.
interface sst_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface sst_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  steps_taken;
  logic [1:0]  hit_class;
  logic [30:0] travel_distance;
  modport source (output valid, steps_taken, hit_class, travel_distance, input ready);
  modport sink (input valid, steps_taken, hit_class, travel_distance, output ready);
endinterface

interface sst_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sst_ctrl.sv
// Sequencer for the march loop: steps the datapath through each ray step.
module sst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sst_pkg::sst_cmd_t cmd_o,
  input  sst_pkg::sst_stat_t stat_i,
  output logic              done_o
);
  import sst_pkg::*;

  sst_state_e state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       second_q, second_d;

  // Hold state and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      second_q <= second_d;
    end
  end

  assign out_valid_o = ovalid_q;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    second_d   = second_q;
    ovalid_d   = ovalid_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.limit_hit) state_d = ST_DONE;
        else state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_WRAP;
      end
      ST_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = ST_MOD;
      end
      ST_MOD: begin
        if (stat_i.mod_done) state_d = ST_SQ;
        else cmd_o.mod_step = 1'b1;
      end
      ST_SQ: begin
        cmd_o.sq         = 1'b1;
        cmd_o.root_start = 1'b1;
        second_d         = 1'b0;
        state_d          = ST_ROOT1;
      end
      ST_ROOT1: begin
        if (stat_i.root_done) begin
          if (stat_i.torus && !second_q) state_d = ST_MID;
          else state_d = ST_DIST;
        end else begin
          cmd_o.root_step = 1'b1;
        end
      end
      ST_MID: begin
        cmd_o.mid        = 1'b1;
        cmd_o.root_start = 1'b1;
        second_d         = 1'b1;
        state_d          = ST_ROOT1;
      end
      ST_DIST: begin
        cmd_o.form_dist = 1'b1;
        state_d         = ST_ADV;
      end
      ST_ADV: begin
        if (stat_i.is_hit) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          done_o   = 1'b1;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/sst_dpath.sv
// March datapath: point forming, wrap by restoring division, shape distance with
// a shared bit-pair integer root, travel accumulate and classify.
module sst_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sst_pkg::sst_cmd_t  cmd_i,
  output sst_pkg::sst_stat_t stat_o,
  input  logic               done_i,
  input  logic signed [31:0] ox_i,
  input  logic signed [31:0] oy_i,
  input  logic signed [31:0] oz_i,
  input  logic signed [15:0] dx_i,
  input  logic signed [15:0] dy_i,
  input  logic signed [15:0] dz_i,
  input  logic [1:0]         shape_i,
  input  logic [23:0]        size_i,
  input  logic [23:0]        period_i,
  input  logic               rep_en_i,
  input  logic [7:0]         max_steps_i,
  input  logic [16:0]        thr_i,
  input  logic [7:0]         far_i,
  output logic [7:0]         steps_o,
  output logic [1:0]         class_o,
  output logic [30:0]        travel_o
);
  import sst_pkg::*;

  localparam int unsigned DirFrac = 15;
  localparam logic [StepWidth-1:0] StepMax = {StepWidth{1'b1}};
  localparam int unsigned ModBits = 50;  // dividend magnitude bits
  localparam int unsigned ModCntW = $clog2(ModBits + 1);
  localparam int unsigned RootCntW = 6;
  localparam logic signed [49:0] CoordMax = 50'sd2147483647;
  localparam logic signed [49:0] CoordMin = -50'sd2147483648;

  logic signed [31:0] ox_q, oy_q, oz_q;
  logic signed [15:0] dx_q, dy_q, dz_q;
  logic [30:0] travel_q;
  logic [StepWidth-1:0] step_q;
  logic [StepWidth-1:0] limit;
  logic signed [47:0] mx_q, my_q, mz_q;
  logic signed [49:0] vx_q, vy_q, vz_q;      // point before modulo
  logic [49:0] rx_q, ry_q, rz_q;             // running remainders (magnitude)
  logic [ModCntW-1:0] mcnt_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [65:0] rad_q;                        // root operand
  logic [65:0] rres_q;
  logic [RootCntW-1:0] rcnt_q;
  logic signed [33:0] dist_q;
  logic signed [33:0] qin_q;                 // box inner term
  logic [7:0] steps_q;
  logic [1:0] class_q;
  logic [30:0] tout_q;

  // Step limit saturated to the counter width
  always_comb begin
    if (StepWidth >= 8) limit = StepWidth'(max_steps_i);
    else if (max_steps_i > 8'(StepMax)) limit = StepMax;
    else limit = StepWidth'(max_steps_i);
  end

  // Floor shift of a product
  function automatic logic signed [49:0] fshift(input logic signed [47:0] v);
    fshift = 50'(v >>> DirFrac);
  endfunction

  logic [23:0] half;
  assign half = period_i >> 1;

  // Wrap offset: enable adds half twice
  logic signed [49:0] wx, wy, wz;
  logic signed [49:0] hoff;
  assign hoff = rep_en_i ? 50'($signed({1'b0, half, 1'b0})) : 50'($signed({1'b0, half}));
  assign wx = 50'(ox_q) + fshift(mx_q) + hoff;
  assign wy = 50'(oy_q) + fshift(my_q) + hoff;
  assign wz = 50'(oz_q) + fshift(mz_q) + hoff;

  function automatic logic [49:0] mag50(input logic signed [49:0] v);
    mag50 = v[49] ? 50'(-v) : 50'(v);
  endfunction

  // One restoring step: shift in dividend bit
  function automatic logic [49:0] mstep(input logic [49:0] r, input logic [49:0] a,
                                       input logic [ModCntW-1:0] i,
                                       input logic [23:0] p);
    logic [50:0] t;
    t = {r, a[i[5:0]]};
    if (t >= 51'(p)) t = t - 51'(p);
    mstep = t[49:0];
  endfunction

  // Final wrap from remainder
  function automatic logic signed [31:0] wfin(input logic signed [49:0] v,
                                              input logic [49:0] r,
                                              input logic [23:0] p,
                                              input logic [23:0] h,
                                              input logic en);
    logic signed [49:0] m;
    m = v;
    if (en && (p != 24'd0)) begin
      if (v[49] && (r != 50'd0)) m = 50'($signed({1'b0, p})) - $signed(r);
      else if (v[49]) m = 50'sd0;
      else m = $signed(r);
    end
    if (en) m = m - 50'($signed({1'b0, h}));
    if (m > CoordMax) wfin = 32'h7fffffff;
    else if (m < CoordMin) wfin = 32'sh80000000;
    else wfin = m[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Box axis excess
  logic signed [33:0] ax, ay, az, amax;
  assign ax = $signed({2'b0, mag32(px_q)}) - $signed({10'b0, size_i});
  assign ay = $signed({2'b0, mag32(py_q)}) - $signed({10'b0, size_i});
  assign az = $signed({2'b0, mag32(pz_q)}) - $signed({10'b0, size_i});
  always_comb begin
    amax = ax;
    if (ay > amax) amax = ay;
    if (az > amax) amax = az;
  end

  // Square of a clipped magnitude (up to 33 bits in)
  function automatic logic [65:0] sqm(input logic signed [33:0] v);
    logic [32:0] m;
    m = v[33] ? 33'(-v) : 33'(v);
    sqm = 66'(m) * 66'(m);
  endfunction

  logic signed [33:0] zer;
  assign zer = '0;

  // Root bit-pair step: test bits from 2^64 down to 2^0
  logic [65:0] rbit;
  assign rbit = 66'd1 << {rcnt_q - 1'b1, 1'b0};

  logic signed [33:0] tube;
  assign tube = $signed({11'b0, size_i[23:1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      class_q <= CLS_MISS;
      tout_q  <= '0;
      mcnt_q  <= '0;
      rcnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        ox_q <= ox_i; oy_q <= oy_i; oz_q <= oz_i;
        dx_q <= dx_i; dy_q <= dy_i; dz_q <= dz_i;
        travel_q <= '0;
        step_q   <= '0;
      end
      if (cmd_i.mul) begin
        mx_q <= 48'(dx_q * $signed({1'b0, travel_q}));
        my_q <= 48'(dy_q * $signed({1'b0, travel_q}));
        mz_q <= 48'(dz_q * $signed({1'b0, travel_q}));
      end
      if (cmd_i.wrap) begin
        vx_q <= wx; vy_q <= wy; vz_q <= wz;
        rx_q <= '0; ry_q <= '0; rz_q <= '0;
        mcnt_q <= ModCntW'(ModBits);
      end
      if (cmd_i.mod_step) begin
        rx_q <= mstep(rx_q, mag50(vx_q), mcnt_q - 1'b1, period_i);
        ry_q <= mstep(ry_q, mag50(vy_q), mcnt_q - 1'b1, period_i);
        rz_q <= mstep(rz_q, mag50(vz_q), mcnt_q - 1'b1, period_i);
        mcnt_q <= mcnt_q - 1'b1;
        if (mcnt_q == ModCntW'(1)) begin
          px_q <= wfin(vx_q, mstep(rx_q, mag50(vx_q), mcnt_q - 1'b1, period_i),
                       period_i, half, rep_en_i);
          py_q <= wfin(vy_q, mstep(ry_q, mag50(vy_q), mcnt_q - 1'b1, period_i),
                       period_i, half, rep_en_i);
          pz_q <= wfin(vz_q, mstep(rz_q, mag50(vz_q), mcnt_q - 1'b1, period_i),
                       period_i, half, rep_en_i);
        end
      end
      if (cmd_i.sq) begin
        case (shape_e'(shape_i))
          SHAPE_BOX: begin
            rad_q <= sqm(ax[33] ? zer : ax) + sqm(ay[33] ? zer : ay) + sqm(az[33] ? zer : az);
            qin_q <= amax[33] ? amax : zer;
          end
          SHAPE_TORUS: rad_q <= sqm(34'(px_q)) + sqm(34'(pz_q));
          default: rad_q <= sqm(34'(px_q)) + sqm(34'(py_q)) + sqm(34'(pz_q));
        endcase
      end
      if (cmd_i.mid) begin
        rad_q <= sqm($signed({1'b0, rres_q[32:0]}) - $signed({10'b0, size_i}))
                 + sqm(34'(py_q));
      end
      if (cmd_i.root_start) begin
        rres_q <= '0;
        rcnt_q <= RootCntW'(33);
      end
      if (cmd_i.root_step) begin
        rcnt_q <= rcnt_q - 1'b1;
        if (rad_q >= (rres_q + rbit)) begin
          rad_q  <= rad_q - (rres_q + rbit);
          rres_q <= (rres_q >> 1) + rbit;
        end else begin
          rres_q <= rres_q >> 1;
        end
      end
      if (cmd_i.form_dist) begin
        case (shape_e'(shape_i))
          SHAPE_BOX:   dist_q <= $signed({1'b0, rres_q[32:0]}) + qin_q;
          SHAPE_TORUS: dist_q <= $signed({1'b0, rres_q[32:0]}) - tube;
          default:     dist_q <= $signed({1'b0, rres_q[32:0]}) - $signed({10'b0, size_i});
        endcase
      end
      if (cmd_i.adv) begin
        step_q <= step_q + 1'b1;
        if ($signed({3'b0, travel_q}) + dist_q > 34'sh7fffffff) travel_q <= 31'h7fffffff;
        else travel_q <= 31'($signed({3'b0, travel_q}) + dist_q);
      end
      if (done_i) begin
        steps_q <= 8'(step_q);
        tout_q  <= travel_q;
        if (step_q < limit) class_q <= (8'(step_q) > far_i) ? CLS_FAR : CLS_NEAR;
        else class_q <= CLS_MISS;
      end
    end
  end

  assign stat_o.mod_done  = (mcnt_q == '0);
  assign stat_o.root_done = (rcnt_q == '0);
  assign stat_o.limit_hit = (step_q >= limit);
  assign stat_o.is_hit    = (dist_q < $signed({17'b0, thr_i}));
  assign stat_o.torus     = (shape_i == SHAPE_TORUS);

  assign steps_o  = steps_q;
  assign class_o  = class_q;
  assign travel_o = tout_q;
endmodule

FILE: rtl/core/sdf_sphere_trace_ray.sv
// Top level of the sphere-tracing ray marcher: config registers, controller, datapath.
//
//  channel   dir  accepted when          payload
//  ray_in    in   valid && ready         origin_x/y/z, dir_x/y/z
//  res_out   out  valid && ready         steps_taken, hit_class, travel_distance
//  cfg       in   valid && ready (ready  index, data
//                 always high)
//
// One ray at a time. A march step runs the wrap's restoring division and then one
// integer root (sphere, box) or two (torus), the torus reusing the root unit for its
// second pass. Reset sets the configuration registers to their defaults. A stalled
// result holds in the output register; the next ray is accepted while it waits.
module sdf_sphere_trace_ray (
  input logic clk_i,
  input logic rst_ni,
  sst_ray_if.sink   ray_in,
  sst_res_if.source res_out,
  sst_cfg_if.sink   cfg
);
  import sst_pkg::*;

  logic [1:0]  shape_q;
  logic [23:0] size_q, period_q;
  logic        rep_en_q;
  logic [7:0]  max_steps_q, far_q;
  logic [16:0] thr_q;

  // Take configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q     <= SHAPE_SPHERE;
      size_q      <= 24'd65536;
      period_q    <= 24'd196608;
      rep_en_q    <= 1'b1;
      max_steps_q <= 8'd32;
      thr_q       <= 17'd66;
      far_q       <= 8'd20;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        REG_SHAPE:     shape_q     <= cfg.data[1:0];
        REG_SIZE:      size_q      <= cfg.data[23:0];
        REG_PERIOD:    period_q    <= cfg.data[23:0];
        REG_REP_EN:    rep_en_q    <= cfg.data[0];
        REG_MAX_STEPS: max_steps_q <= cfg.data[7:0];
        REG_HIT_THR:   thr_q       <= cfg.data[16:0];
        REG_FAR_LIM:   far_q       <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  sst_cmd_t  cmd;
  sst_stat_t stat;
  logic      done;

  sst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (ray_in.valid),
    .in_ready_o  (ray_in.ready),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .done_o      (done)
  );

  sst_dpath u_dpath (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .stat_o (stat), .done_i (done),
    .ox_i (ray_in.origin_x), .oy_i (ray_in.origin_y), .oz_i (ray_in.origin_z),
    .dx_i (ray_in.dir_x), .dy_i (ray_in.dir_y), .dz_i (ray_in.dir_z),
    .shape_i (shape_q), .size_i (size_q), .period_i (period_q),
    .rep_en_i (rep_en_q), .max_steps_i (max_steps_q), .thr_i (thr_q), .far_i (far_q),
    .steps_o (res_out.steps_taken), .class_o (res_out.hit_class),
    .travel_o (res_out.travel_distance)
  );
endmodule
